// File: src/rpb_pkg.sv
`timescale 1ns / 1ps

package rpb_pkg;

    // Patrol sequence lengths, in ticks.
    localparam int unsigned FORWARD_TICKS   = 60;
    localparam int unsigned PIVOT_END_TICKS = 75;

    localparam int unsigned US_PER_S = 1000000;

    // Width of the idle limit in microseconds: (255 + 1) * 10^6 stays below 2^28.
    localparam int unsigned IDLE_LIMIT_W = 28;

    // Fixed speeds, percent.
    localparam logic [6:0] SPEED_MAX   = 7'd100;
    localparam logic [6:0] SPEED_FIRE  = 7'd40;
    localparam logic [6:0] SPEED_AVOID = 7'd30;
    localparam logic [6:0] SPEED_SLOW  = 7'd20;
    localparam logic [6:0] SPEED_PIVOT = 7'd35;

    // Configuration register indexes.
    localparam logic [7:0] CFG_GAS_THRESHOLD    = 8'd0;
    localparam logic [7:0] CFG_BATTERY_LOW_MV   = 8'd1;
    localparam logic [7:0] CFG_BATTERY_FLOOR_MV = 8'd2;
    localparam logic [7:0] CFG_OBSTACLE_NEAR_MM = 8'd3;
    localparam logic [7:0] CFG_OBSTACLE_SLOW_MM = 8'd4;
    localparam logic [7:0] CFG_PATROL_SPEED     = 8'd5;
    localparam logic [7:0] CFG_IDLE_TIMEOUT_S   = 8'd6;

    // Behaviour codes as they appear on the result word.
    localparam logic [2:0] BEH_IDLE   = 3'd0;
    localparam logic [2:0] BEH_PATROL = 3'd1;
    localparam logic [2:0] BEH_AVOID  = 3'd2;
    localparam logic [2:0] BEH_FIRE   = 3'd3;
    localparam logic [2:0] BEH_GAS    = 3'd4;
    localparam logic [2:0] BEH_LOWBAT = 3'd5;
    localparam logic [2:0] BEH_MANUAL = 3'd6;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PATROL = 7'b0000010,
        ST_AVOID  = 7'b0000100,
        ST_FIRE   = 7'b0001000,
        ST_GAS    = 7'b0010000,
        ST_LOWBAT = 7'b0100000,
        ST_MANUAL = 7'b1000000
    } behav_state_t;

    typedef enum logic [2:0] {
        MOT_STOP        = 3'd0,
        MOT_FORWARD     = 3'd1,
        MOT_BACKWARD    = 3'd2,
        MOT_PIVOT_LEFT  = 3'd3,
        MOT_PIVOT_RIGHT = 3'd4
    } motion_t;

    typedef struct packed {
        logic [47:0] now_us;
        logic [11:0] front_mm;
        logic [11:0] rear_mm;
        logic [11:0] left_mm;
        logic [9:0]  gas_frac;
        logic [14:0] battery_mv;
        logic        flame;
        logic        smoke;
        logic        remote_ctrl;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  behavior_state;
        motion_t     drive_cmd;
        logic        motion_valid;
        logic [6:0]  speed;
        logic        pump_on;
        logic        buzzer_on;
        logic        alert;
        logic        state_changed;
        logic [31:0] change_count;
    } out_item_t;

    // Live configuration. The patrol speed is held already clamped to 100 and
    // the idle timeout as the elapsed microseconds at which patrol starts.
    typedef struct packed {
        logic [9:0]              gas_threshold;
        logic [14:0]             battery_low_mv;
        logic [14:0]             battery_floor_mv;
        logic [11:0]             obstacle_near_mm;
        logic [11:0]             obstacle_slow_mm;
        logic [6:0]              patrol_pct;
        logic [IDLE_LIMIT_W-1:0] idle_limit_us;
    } cfg_t;

    typedef struct packed {
        behav_state_t behavior;
        logic [47:0]  entered_at_us;
        logic [6:0]   patrol_count;
        logic         patrol_parity;
        logic [31:0]  changes_total;
    } st_t;

    function automatic logic [2:0] behav_code(input behav_state_t s);
        logic [2:0] code;
        case (s)
            ST_IDLE:   code = BEH_IDLE;
            ST_PATROL: code = BEH_PATROL;
            ST_AVOID:  code = BEH_AVOID;
            ST_FIRE:   code = BEH_FIRE;
            ST_GAS:    code = BEH_GAS;
            ST_LOWBAT: code = BEH_LOWBAT;
            ST_MANUAL: code = BEH_MANUAL;
            default:   code = BEH_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: src/rpb_cfg.sv
`timescale 1ns / 1ps

module rpb_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output rpb_pkg::cfg_t cfg
);
    import rpb_pkg::*;

    cfg_t                    cfg_reg;
    logic [6:0]              pct_next;
    logic [IDLE_LIMIT_W-1:0] limit_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Clamp once on write so the decision path sees a ready speed.
    assign pct_next = (cfg_data[6:0] > SPEED_MAX) ? SPEED_MAX : cfg_data[6:0];

    // More than T whole seconds elapsed is the same as at least (T + 1) * 10^6 us.
    assign limit_next = (IDLE_LIMIT_W'(cfg_data[7:0]) + IDLE_LIMIT_W'(1))
                        * IDLE_LIMIT_W'(US_PER_S);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gas_threshold    <= 10'd717;
            cfg_reg.battery_low_mv   <= 15'd6500;
            cfg_reg.battery_floor_mv <= 15'd1000;
            cfg_reg.obstacle_near_mm <= 12'd200;
            cfg_reg.obstacle_slow_mm <= 12'd400;
            cfg_reg.patrol_pct       <= 7'd50;
            cfg_reg.idle_limit_us    <= IDLE_LIMIT_W'(6 * US_PER_S);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_GAS_THRESHOLD:    cfg_reg.gas_threshold    <= cfg_data[9:0];
                CFG_BATTERY_LOW_MV:   cfg_reg.battery_low_mv   <= cfg_data[14:0];
                CFG_BATTERY_FLOOR_MV: cfg_reg.battery_floor_mv <= cfg_data[14:0];
                CFG_OBSTACLE_NEAR_MM: cfg_reg.obstacle_near_mm <= cfg_data[11:0];
                CFG_OBSTACLE_SLOW_MM: cfg_reg.obstacle_slow_mm <= cfg_data[11:0];
                CFG_PATROL_SPEED:     cfg_reg.patrol_pct       <= pct_next;
                CFG_IDLE_TIMEOUT_S:   cfg_reg.idle_limit_us    <= limit_next;
                default: begin
                end
            endcase
        end
    end

endmodule

// File: src/rpb_rules.sv
`timescale 1ns / 1ps

module rpb_rules (
    input  rpb_pkg::in_item_t  item,
    input  rpb_pkg::cfg_t      cfg,
    input  rpb_pkg::st_t       st,
    output rpb_pkg::st_t       st_next,
    output rpb_pkg::out_item_t result
);
    import rpb_pkg::*;

    logic [47:0]  elapsed_us;
    logic         idle_due;
    logic         has_front;
    logic [6:0]   count_inc;
    behav_state_t beh;
    motion_t      cmd;
    logic [6:0]   spd;
    logic         pump;
    logic         buzz;
    logic         alrt;
    logic         changed;

    assign elapsed_us = item.now_us - st.entered_at_us;
    assign idle_due   = elapsed_us >= 48'(cfg.idle_limit_us);
    assign has_front  = item.front_mm != 12'd0;
    assign count_inc  = st.patrol_count + 7'd1;

    always_comb begin
        st_next = st;
        beh     = ST_IDLE;
        cmd     = MOT_STOP;
        spd     = 7'd0;
        pump    = 1'b0;
        buzz    = 1'b0;
        alrt    = 1'b0;

        if (item.remote_ctrl) begin
            beh = ST_MANUAL;
        end else if (item.gas_frac > cfg.gas_threshold) begin
            beh  = ST_GAS;
            pump = 1'b1;
            buzz = 1'b1;
            alrt = 1'b1;
        end else if (item.flame || item.smoke) begin
            beh  = ST_FIRE;
            cmd  = MOT_BACKWARD;
            spd  = SPEED_FIRE;
            pump = 1'b1;
            buzz = 1'b1;
            alrt = 1'b1;
        end else if (item.battery_mv < cfg.battery_low_mv
                     && item.battery_mv > cfg.battery_floor_mv) begin
            beh  = ST_LOWBAT;
            alrt = 1'b1;
        end else if (has_front && item.front_mm < cfg.obstacle_near_mm) begin
            beh = ST_AVOID;
            cmd = (item.left_mm > item.rear_mm) ? MOT_PIVOT_LEFT : MOT_PIVOT_RIGHT;
            spd = SPEED_AVOID;
        end else if (has_front && item.front_mm < cfg.obstacle_slow_mm) begin
            beh = ST_PATROL;
            cmd = MOT_FORWARD;
            spd = SPEED_SLOW;
        end else if (st.behavior == ST_IDLE && idle_due) begin
            beh = ST_PATROL;
            cmd = MOT_FORWARD;
            spd = cfg.patrol_pct;
        end else if (st.behavior == ST_PATROL) begin
            st_next.patrol_count = count_inc;
            if (count_inc < 7'(FORWARD_TICKS)) begin
                beh = ST_PATROL;
                cmd = MOT_FORWARD;
                spd = cfg.patrol_pct;
            end else if (count_inc < 7'(PIVOT_END_TICKS)) begin
                beh = ST_PATROL;
                cmd = st.patrol_parity ? MOT_PIVOT_RIGHT : MOT_PIVOT_LEFT;
                spd = SPEED_PIVOT;
            end else begin
                // End of one lap: rest in idle, and pivot the other way next time.
                st_next.patrol_count  = 7'd0;
                st_next.patrol_parity = ~st.patrol_parity;
            end
        end

        changed = beh != st.behavior;
        if (changed) begin
            st_next.behavior      = beh;
            st_next.entered_at_us = item.now_us;
            st_next.changes_total = st.changes_total + 32'd1;
        end

        result.behavior_state = behav_code(beh);
        result.drive_cmd      = cmd;
        result.motion_valid   = ~item.remote_ctrl;
        result.speed          = spd;
        result.pump_on        = pump;
        result.buzzer_on      = buzz;
        result.alert          = alrt;
        result.state_changed  = changed;
        result.change_count   = st_next.changes_total;
    end

endmodule

// File: src/robot_priority_behavior_fsm.sv
`timescale 1ns / 1ps

// Priority behaviour controller for a patrol robot. Each input word is one
// decision tick (a microsecond timestamp and a sensor snapshot) and yields
// exactly one result word: behaviour state, motion command and speed, pump,
// buzzer and alert drives, a state-changed flag and a running count of state
// changes. Rules are tried in the order manual override, gas, fire, low
// battery, near obstacle, moderate obstacle, idle timeout and patrol sequence.
// The block takes one word per clock while the result register drains: the
// whole rule set is evaluated in a single pass between the input register and
// the result register, and m_valid rises when the word moves from the input
// register into the result register. A stalled m_ready holds the result
// register, and once the input register is also full s_ready drops. The pass
// also updates the behaviour state, so the next word sees it with no bubble;
// the longest path in that pass is the 48-bit elapsed-time subtract and
// compare against the idle limit. The result register and the input register
// together let a new word in while a finished result still waits for m_ready.
// Configuration writes on the cfg_ port are always accepted and must only be
// made while no word is in flight; after reset the registers hold gas
// threshold 717, battery low 6500 mV, battery floor 1000 mV, near 200 mm,
// slow 400 mm, patrol speed 50 % and idle timeout 5 s.

module robot_priority_behavior_fsm (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  rpb_pkg::in_item_t  s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output rpb_pkg::out_item_t m_data,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import rpb_pkg::*;

    cfg_t         cfg;

    // Input register and result register, each with its own valid flag.
    logic         in_valid_reg;
    in_item_t     in_item_reg;
    logic         out_valid_reg;
    out_item_t    out_item_reg;

    // Behaviour state carried from tick to tick.
    st_t          st_reg;
    st_t          st_next;
    behav_state_t prior_reg;

    out_item_t    result;
    logic         advance;

    // A word moves from the input register to the result register whenever
    // the result register is empty or is being emptied in the same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    rpb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rpb_rules u_rules (
        .item    (in_item_reg),
        .cfg     (cfg),
        .st      (st_reg),
        .st_next (st_next),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{behavior: ST_IDLE, entered_at_us: '0, patrol_count: '0,
                               patrol_parity: 1'b0, changes_total: '0};
            prior_reg     <= ST_IDLE;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            // State moves only with the word whose rules produced it.
            if (advance) begin
                st_reg <= st_next;
                if (result.state_changed) begin
                    prior_reg <= st_reg.behavior;
                end
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    // The change count grows by one exactly for each word that changes state.
    a_count_tracks_changes: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> st_reg.changes_total
                    == $past(st_reg.changes_total) + 32'($past(result.state_changed)))
        else $error("change count out of step with state changes");

    // Without a word passing through, the behaviour state does not move.
    a_state_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg))
        else $error("behaviour state moved with no word");

    // On a change the previous behaviour is kept as the prior one.
    a_prior_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.state_changed |=> prior_reg == $past(st_reg.behavior))
        else $error("prior behaviour not recorded on change");

    // The patrol lap counter wraps before reaching the end of the pivot phase.
    a_patrol_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.patrol_count < 7'(PIVOT_END_TICKS))
        else $error("patrol count beyond end of lap");

    // Under manual override no motion command is issued.
    a_manual_no_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.behavior_state == BEH_MANUAL |-> !m_data.motion_valid)
        else $error("motion issued under manual override");

endmodule
